[rtl/core/infix_add_sub_evaluator_core_defines.svh]
// assertion macros for the infix add/sub evaluator core
`ifndef INFIX_ADD_SUB_EVALUATOR_CORE_DEFINES_SVH
`define INFIX_ADD_SUB_EVALUATOR_CORE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define IAS_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition that must never be seen outside reset
`define IAS_ASSERT_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

[rtl/core/ias_pkg.sv]
// shared constants, codes and stage structs of the infix add/sub evaluator
package ias_pkg;

	localparam int NEST_DEPTH  = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int LVL_W       = $clog2(NEST_DEPTH + 1);
	localparam int ADDR_W      = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

	localparam int CHAR_W   = 8;
	localparam int STATUS_W = 3;
	localparam int RESULT_W = 32;
	localparam int OUT_DATA_W = ((RESULT_W + STATUS_W + 7) / 8) * 8;

	// character codes
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
	localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UNMATCHED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_UNCLOSED  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;

	// operation codes handed from decode to the datapath
	typedef logic [2:0] op_t;
	localparam op_t OP_NOP   = 3'd0;
	localparam op_t OP_DIGIT = 3'd1;
	localparam op_t OP_ADD   = 3'd2;
	localparam op_t OP_SUB   = 3'd3;
	localparam op_t OP_PUSH  = 3'd4;
	localparam op_t OP_POP   = 3'd5;

	typedef logic [VALUE_WIDTH-1:0] val_t;

	typedef struct packed {
		logic                valid;
		op_t                 op;
		logic [3:0]          digit;
		logic                last;
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   addr;
	} item_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} rd_req_t;

	typedef struct packed {
		logic                valid;
		val_t                sum;
		val_t                pend;
		logic                neg;
		logic [STATUS_W-1:0] status;
	} fin_t;

endpackage

[rtl/core/ias_ctrl.sv]
// character decode, nesting level and sticky status tracking (stage 1)
module ias_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          s_fire,
	input  logic [ias_pkg::CHAR_W-1:0]    char_code,
	input  logic                          last,
	output ias_pkg::item_t                item_s1,
	output ias_pkg::rd_req_t              rd_req
);
	import ias_pkg::*;

	logic [LVL_W-1:0]    level_q;
	logic [STATUS_W-1:0] err_q;
	logic [LVL_W-1:0]    level_n;
	logic [LVL_W-1:0]    level_dec;
	logic [STATUS_W-1:0] flag_code;
	logic [STATUS_W-1:0] err_n;
	logic [STATUS_W-1:0] err_fin;
	item_t               item_n;
	logic                is_space;

	assign level_dec = level_q - LVL_W'(1);
	assign is_space  = (char_code == CH_SPACE) ||
		((char_code >= CH_TAB) && (char_code <= CH_CR));

	always_comb begin
		item_n        = '0;
		item_n.valid  = 1'b1;
		item_n.op     = OP_NOP;
		item_n.digit  = 4'(char_code - CH_ZERO);
		item_n.last   = last;
		item_n.addr   = level_q[ADDR_W-1:0];
		level_n       = level_q;
		flag_code     = ST_OK;
		if ((char_code >= CH_ZERO) && (char_code <= CH_NINE)) begin
			item_n.op = OP_DIGIT;
		end else if (char_code == CH_PLUS) begin
			item_n.op = OP_ADD;
		end else if (char_code == CH_MINUS) begin
			item_n.op = OP_SUB;
		end else if (char_code == CH_OPEN) begin
			if (level_q == LVL_W'(NEST_DEPTH)) begin
				flag_code = ST_OVERFLOW;
			end else begin
				item_n.op = OP_PUSH;
				level_n   = level_q + LVL_W'(1);
			end
		end else if (char_code == CH_CLOSE) begin
			if (level_q == '0) begin
				flag_code = ST_UNMATCHED;
			end else begin
				item_n.op   = OP_POP;
				item_n.addr = level_dec[ADDR_W-1:0];
				level_n     = level_dec;
			end
		end else if (!is_space) begin
			flag_code = ST_INVALID;
		end

		err_n   = (err_q == ST_OK) ? flag_code : err_q;
		err_fin = err_n;
		if ((err_n == ST_OK) && (level_n != '0)) begin
			err_fin = ST_UNCLOSED;
		end
		item_n.status = err_fin;
	end

	// pop reads the saved entry as the character is taken
	assign rd_req.en   = s_fire && (item_n.op == OP_POP);
	assign rd_req.addr = item_n.addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			err_q   <= ST_OK;
		end else if (s_fire) begin
			if (last) begin
				level_q <= '0;
				err_q   <= ST_OK;
			end else begin
				level_q <= level_n;
				err_q   <= err_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (adv) begin
			item_s1 <= s_fire ? item_n : '0;
		end
	end

endmodule

[rtl/core/ias_stack_dp.sv]
// saved sum/sign stack memory and running-sum arithmetic (stage 2)
module ias_stack_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  ias_pkg::item_t   item_s1,
	input  ias_pkg::rd_req_t rd_req,
	output ias_pkg::fin_t    fin_s2
);
	import ias_pkg::*;

	logic [VALUE_WIDTH:0] stack_mem [NEST_DEPTH];
	logic [VALUE_WIDTH:0] rdata_q;
	logic [VALUE_WIDTH:0] fwd_data_q;
	logic                 fwd_q;

	val_t run_q;
	val_t pend_q;
	logic neg_q;

	val_t run_n;
	val_t pend_n;
	logic neg_n;
	val_t mul10;
	val_t fold;
	val_t pop_sum;
	logic [VALUE_WIDTH:0] saved;
	logic wr_en;

	assign wr_en = adv && item_s1.valid && (item_s1.op == OP_PUSH);

	// one write port (push), one read port (pop), read data registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[item_s1.addr] <= {neg_q, run_q};
		end
		if (rd_req.en) begin
			rdata_q <= stack_mem[rd_req.addr];
		end
	end

	// push directly followed by pop of the same entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_req.en) begin
			fwd_q <= wr_en && (item_s1.addr == rd_req.addr);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_req.en) begin
			fwd_data_q <= {neg_q, run_q};
		end
	end

	assign saved   = fwd_q ? fwd_data_q : rdata_q;
	assign mul10   = (pend_q << 3) + (pend_q << 1) + val_t'(item_s1.digit);
	assign fold    = neg_q ? (run_q - pend_q) : (run_q + pend_q);
	assign pop_sum = saved[VALUE_WIDTH] ? (saved[VALUE_WIDTH-1:0] - fold)
		: (saved[VALUE_WIDTH-1:0] + fold);

	always_comb begin
		run_n  = run_q;
		pend_n = pend_q;
		neg_n  = neg_q;
		case (item_s1.op)
			OP_DIGIT: begin
				pend_n = mul10;
			end
			OP_ADD, OP_SUB: begin
				run_n  = fold;
				pend_n = '0;
				neg_n  = (item_s1.op == OP_SUB);
			end
			OP_PUSH: begin
				run_n  = '0;
				pend_n = '0;
				neg_n  = 1'b0;
			end
			OP_POP: begin
				run_n  = pop_sum;
				pend_n = '0;
				neg_n  = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= '0;
			pend_q <= '0;
			neg_q  <= 1'b0;
		end else if (adv && item_s1.valid) begin
			if (item_s1.last) begin
				run_q  <= '0;
				pend_q <= '0;
				neg_q  <= 1'b0;
			end else begin
				run_q  <= run_n;
				pend_q <= pend_n;
				neg_q  <= neg_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_s2 <= '0;
		end else if (adv) begin
			fin_s2.valid  <= item_s1.valid && item_s1.last;
			fin_s2.sum    <= run_n;
			fin_s2.pend   <= pend_n;
			fin_s2.neg    <= neg_n;
			fin_s2.status <= item_s1.status;
		end
	end

endmodule

[rtl/core/ias_out.sv]
// final fold and output register of the result stream (stage 3)
module ias_out (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ias_pkg::fin_t                     fin_s2,
	input  logic                              m_tready,
	output logic                              m_tvalid,
	output logic [ias_pkg::OUT_DATA_W-1:0]    m_tdata
);
	import ias_pkg::*;

	logic                valid_s3;
	logic [RESULT_W-1:0] value_s3;
	logic [STATUS_W-1:0] status_s3;
	logic                load;
	val_t                res;

	assign load = fin_s2.valid && (!valid_s3 || m_tready);
	assign res  = fin_s2.neg ? (fin_s2.sum - fin_s2.pend) : (fin_s2.sum + fin_s2.pend);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (load) begin
			valid_s3 <= 1'b1;
		end else if (m_tready) begin
			valid_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_s3 <= fin_s2.status;
			value_s3  <= (fin_s2.status != ST_OK) ? '0 : RESULT_W'(signed'(res));
		end
	end

	assign m_tvalid = valid_s3;
	assign m_tdata  = OUT_DATA_W'({status_s3, value_s3});

endmodule

[rtl/core/infix_add_sub_evaluator_core.sv]
// m_tvalid rises once the transaction carrying the last character has passed item_s1, fin_s2 and the output register
// throughput: one character per cycle while s_tready is high; the stack memory read for ')' issues at accept
// and a push just before it is forwarded, so nesting never stalls the stream
// s_tready drops only while one result waits in the output register and another is behind it
// reset clears sum, pending number, sign, nesting level and status; the stack is not cleared
`include "infix_add_sub_evaluator_core_defines.svh"

module infix_add_sub_evaluator_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // [7:0] char_code
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [ias_pkg::OUT_DATA_W-1:0]    m_tdata    // [31:0] value, [34:32] status
);
	import ias_pkg::*;

	logic    adv;
	logic    s_fire;
	item_t   item_s1;
	rd_req_t rd_req;
	fin_t    fin_s2;

	// whole pipe moves unless a finished result is blocked behind the output
	assign adv      = !fin_s2.valid || !m_tvalid || m_tready;
	assign s_tready = adv;
	assign s_fire   = s_tvalid && adv;

	ias_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.s_fire    (s_fire),
		.char_code (s_tdata),
		.last      (s_tlast),
		.item_s1   (item_s1),
		.rd_req    (rd_req)
	);

	ias_stack_dp u_stack_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.item_s1 (item_s1),
		.rd_req  (rd_req),
		.fin_s2  (fin_s2)
	);

	ias_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.fin_s2   (fin_s2),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

	`IAS_ASSERT_IMP(a_stall_only_when_full, !s_tready, m_tvalid && !m_tready && fin_s2.valid, "input stalled without a blocked result")
	`IAS_ASSERT_IMP(a_error_zero_value, m_tvalid && (m_tdata[34:32] != ST_OK), m_tdata[31:0] == '0, "error result with nonzero value")
	`IAS_ASSERT_NEVER(a_status_range, m_tvalid && (m_tdata[34:32] > ST_INVALID), "status code out of range")
	`IAS_ASSERT_NEVER(a_pop_without_item, rd_req.en && !s_fire, "stack read without an accepted transaction")

endmodule

[sim/tb_infix_add_sub_evaluator_core.sv]
// self-checking testbench for the infix add/sub expression evaluator core
module tb_infix_add_sub_evaluator_core;
	timeunit 1ns;
	timeprecision 1ps;

	import ias_pkg::*;

	localparam int PHASE_CHARS    = 320;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		logic [RESULT_W-1:0] value;
		logic [STATUS_W-1:0] status;
	} eval_t;

	typedef struct {
		string               text;
		bit                  nul_lead;
		bit                  typed;
		logic [RESULT_W-1:0] value;
		logic [STATUS_W-1:0] status;
	} dir_row_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata  = 8'h00;
	logic                  s_tlast  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	// evaluator state mirrored by the predictor
	val_t                run_sum  = '0;
	val_t                pend_num = '0;
	bit                  pend_neg = 1'b0;
	val_t                save_sum [NEST_DEPTH];
	bit                  save_neg [NEST_DEPTH];
	int                  level    = 0;
	logic [STATUS_W-1:0] err      = ST_OK;

	eval_t      expected_evals[$];
	logic [7:0] text_q[$];

	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int hold_reqs    = 0;
	int holds_served = 0;
	int hold_left    = 0;
	int stall_cycles = 0;
	int mismatches   = 0;
	int sent_chars   = 0;
	int expr_count   = 0;
	int status_seen [5] = '{default: 0};

	int phase_tx [4] = '{0, 75, 0, 33};
	int phase_rx [4] = '{0, 0, 75, 33};

	dir_row_t dir_rows [11] = '{
		'{"0",                  0, 1, 32'h0000_0000, ST_OK},
		'{"-(3)",               0, 1, 32'hFFFF_FFFD, ST_OK},
		'{"0-1",                0, 1, 32'hFFFF_FFFF, ST_OK},
		'{"1 2+3",              0, 1, 32'd15,        ST_OK},
		'{"1\t\n\v\f\0152",     0, 1, 32'd12,        ST_OK},
		'{")",                  0, 1, 32'h0000_0000, ST_UNMATCHED},
		'{"(",                  0, 1, 32'h0000_0000, ST_UNCLOSED},
		'{")(",                 0, 1, 32'h0000_0000, ST_UNMATCHED},
		'{"9\377",              0, 1, 32'h0000_0000, ST_INVALID},
		'{")",                  1, 1, 32'h0000_0000, ST_INVALID},
		'{"5-(-4)+(1)",         0, 0, 32'h0000_0000, ST_OK}
	};

	infix_add_sub_evaluator_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void merge_term();
		run_sum  = pend_neg ? run_sum - pend_num : run_sum + pend_num;
		pend_num = '0;
		pend_neg = 1'b0;
	endfunction

	// first error wins
	function automatic void latch_status(input logic [STATUS_W-1:0] code);
		if (err == ST_OK)
			err = code;
	endfunction

	function automatic bit eval_char(input logic [7:0] c, input bit lst, output eval_t r);
		r = '0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			pend_num = pend_num * 10 + val_t'(c - CH_ZERO);
		end else if (c == CH_PLUS || c == CH_MINUS) begin
			merge_term();
			pend_neg = (c == CH_MINUS);
		end else if (c == CH_OPEN) begin
			if (level >= NEST_DEPTH) begin
				latch_status(ST_OVERFLOW);
			end else begin
				save_sum[level] = run_sum;
				save_neg[level] = pend_neg;
				level++;
				run_sum  = '0;
				pend_num = '0;
				pend_neg = 1'b0;
			end
		end else if (c == CH_CLOSE) begin
			if (level == 0) begin
				latch_status(ST_UNMATCHED);
			end else begin
				merge_term();
				level--;
				run_sum = save_neg[level] ? save_sum[level] - run_sum : save_sum[level] + run_sum;
			end
		end else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
			latch_status(ST_INVALID);
		end
		if (!lst)
			return 1'b0;
		merge_term();
		if (level != 0)
			latch_status(ST_UNCLOSED);
		r.value  = (err == ST_OK) ? RESULT_W'(signed'(run_sum)) : '0;
		r.status = err;
		run_sum  = '0;
		level    = 0;
		err      = ST_OK;
		return 1'b1;
	endfunction

	// appends one character to the expression being built
	function automatic void queue_char(input logic [7:0] c);
		text_q.insert(text_q.size(), c);
	endfunction

	function automatic void add_number();
		int n_digits;
		n_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 3);
		repeat (n_digits)
			queue_char(CH_ZERO + 8'($urandom_range(0, 9)));
	endfunction

	// mostly well-formed expressions, some deep nesting, some broken, some noise
	function automatic void build_expr();
		int  pick;
		int  depth;
		int  pos;
		bit  want_operand;
		text_q.delete();
		pick = $urandom_range(1, 100);
		if (pick <= 8) begin
			repeat ($urandom_range(1, 6))
				queue_char(8'($urandom_range(0, 255)));
			return;
		end
		if (pick <= 12) begin
			depth = $urandom_range(56, 70);
			repeat (depth) begin
				if ($urandom_range(0, 3) == 0)
					queue_char(CH_MINUS);
				queue_char(CH_OPEN);
			end
			add_number();
			repeat (depth)
				queue_char(CH_CLOSE);
			return;
		end
		depth        = 0;
		want_operand = 1'b1;
		if ($urandom_range(0, 4) == 0)
			queue_char(CH_MINUS);
		repeat ($urandom_range(1, 10)) begin
			if ($urandom_range(0, 6) == 0)
				queue_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4)));
			if (want_operand) begin
				if ($urandom_range(0, 3) == 0 && depth < 6) begin
					if ($urandom_range(0, 1))
						queue_char(CH_MINUS);
					queue_char(CH_OPEN);
					depth++;
				end else begin
					add_number();
					want_operand = 1'b0;
				end
			end else if (depth > 0 && $urandom_range(0, 2) == 0) begin
				queue_char(CH_CLOSE);
				depth--;
			end else begin
				queue_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
				want_operand = 1'b1;
			end
		end
		if (want_operand)
			add_number();
		repeat (depth)
			queue_char(CH_CLOSE);
		if (pick <= 30) begin
			pos = $urandom_range(0, text_q.size());
			case ($urandom_range(0, 2))
				0: text_q.insert(pos, CH_CLOSE);
				1: text_q.insert(pos, CH_OPEN);
				default: text_q.insert(pos, 8'($urandom_range(0, 255)));
			endcase
		end
	endfunction

	// push one expression through the slave side, last flag on its final character
	task automatic send_text(input bit typed, input eval_t want);
		eval_t got;
		foreach (text_q[i]) begin
			if ($urandom_range(1, 100) <= tx_idle_pct) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while ($urandom_range(1, 100) <= tx_idle_pct);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= text_q[i];
			s_tlast  <= (i == text_q.size() - 1);
			do @(posedge clk); while (!s_tready);
			sent_chars++;
			if (eval_char(text_q[i], i == text_q.size() - 1, got)) begin
				expected_evals.insert(expected_evals.size(), typed ? want : got);
				expr_count++;
			end
		end
	endtask

	function automatic void report(input string what);
		if (mismatches < MAX_REPORTS)
			$display("%t: %s", $realtime, what);
		mismatches++;
	endfunction

	// result receiver with random stalls and on-request long hold-offs
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_served != hold_reqs) begin
			holds_served <= hold_reqs;
			hold_left    <= HOLD_CYCLES;
			m_tready     <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(1, 100) > rx_stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		eval_t seen;
		eval_t want;
		if (arst_n && m_tvalid && m_tready) begin
			seen.value  = m_tdata[RESULT_W-1:0];
			seen.status = m_tdata[RESULT_W+STATUS_W-1:RESULT_W];
			if (seen.status <= ST_INVALID)
				status_seen[seen.status]++;
			if (expected_evals.size() == 0) begin
				report($sformatf("unexpected result value %h status %0d",
					seen.value, seen.status));
			end else begin
				want = expected_evals.pop_front();
				if (seen.value !== want.value)
					report($sformatf("value mismatch: expected %h got %h",
						want.value, seen.value));
				if (seen.status !== want.status)
					report($sformatf("status mismatch: expected %0d got %0d",
						want.status, seen.status));
			end
		end
	end

	// ends the run when no transaction moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, expected_evals.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin : stimulus
		int phase_end;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			text_q.delete();
			if (dir_rows[r].nul_lead)
				queue_char(8'h00);
			for (int k = 0; k < dir_rows[r].text.len(); k++)
				queue_char(dir_rows[r].text[k]);
			send_text(dir_rows[r].typed, '{value: dir_rows[r].value, status: dir_rows[r].status});
		end

		for (int ph = 0; ph < 4; ph++) begin
			tx_idle_pct  = phase_tx[ph];
			rx_stall_pct <= phase_rx[ph];
			// long receiver hold-off so the core backs up into its input
			if (ph == 0)
				hold_reqs <= hold_reqs + 1;
			phase_end = sent_chars + PHASE_CHARS;
			while (sent_chars < phase_end) begin
				build_expr();
				send_text(1'b0, '0);
			end
		end
		s_tvalid <= 1'b0;

		while (expected_evals.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d characters in %0d expressions across four flow-control phases",
			sent_chars, expr_count);
		$display("results by status: ok %0d, unmatched %0d, overflow %0d, unclosed %0d, invalid %0d",
			status_seen[ST_OK], status_seen[ST_UNMATCHED], status_seen[ST_OVERFLOW],
			status_seen[ST_UNCLOSED], status_seen[ST_INVALID]);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
